/* design/hrt_pkg.sv */
// ----------------------------------------------------------------------------
// HTTP request header tokenizer package
// Shared constants, codes, types and the method name table.
// ----------------------------------------------------------------------------
package hrt_pkg;

    localparam logic [11:0] LINE_LIMIT_MAX  = 12'd4095;
    localparam logic [11:0] MAX_LEN_RESET   = 12'd3000;

    localparam logic [7:0]  CH_LF    = 8'h0A;
    localparam logic [7:0]  CH_CR    = 8'h0D;
    localparam logic [7:0]  CH_SPACE = 8'h20;
    localparam logic [7:0]  CH_COLON = 8'h3A;

    localparam int          NUM_METHODS    = 8;
    localparam logic [3:0]  METHOD_UNKNOWN = 4'd0;
    localparam logic [3:0]  POS_MAX        = 4'd15;

    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_URL     = 3'd1,
        PH_REST    = 3'd2,
        PH_NAME    = 3'd3,
        PH_SKIP    = 3'd4,
        PH_VALUE   = 3'd5,
        PH_DISCARD = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        KIND_METHOD = 3'd0,
        KIND_URL    = 3'd1,
        KIND_REST   = 3'd2,
        KIND_NAME   = 3'd3,
        KIND_VALUE  = 3'd4,
        KIND_NONE   = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        LK_REQUEST = 2'd0,
        LK_HEADER  = 2'd1,
        LK_EMPTY   = 2'd2
    } t_line_kind;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_LONG = 2'd1,
        ERR_REQ  = 2'd2,
        ERR_HDR  = 2'd3
    } t_err;

    typedef struct packed {
        logic [7:0] byte_out;
        t_kind      byte_kind;
        logic       line_end;
        t_line_kind line_kind;
        logic [3:0] method_code;
        logic       request_done;
        t_err       line_error;
    } t_result;

    typedef struct packed {
        logic [7:0] cands;
        logic [3:0] pos;
        logic [3:0] code;
    } t_match;

    // HEAD OPTIONS GET POST PUT DELETE TRACE CONNECT, ASCII, zero padded
    localparam logic [7:0] METHOD_CHARS [NUM_METHODS][8] = '{
        '{8'h48, 8'h45, 8'h41, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4F, 8'h50, 8'h54, 8'h49, 8'h4F, 8'h4E, 8'h53, 8'h00},
        '{8'h47, 8'h45, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h55, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h44, 8'h45, 8'h4C, 8'h45, 8'h54, 8'h45, 8'h00, 8'h00},
        '{8'h54, 8'h52, 8'h41, 8'h43, 8'h45, 8'h00, 8'h00, 8'h00},
        '{8'h43, 8'h4F, 8'h4E, 8'h4E, 8'h45, 8'h43, 8'h54, 8'h00}
    };

    localparam logic [3:0] METHOD_LENS [NUM_METHODS] = '{
        4'd4, 4'd7, 4'd3, 4'd4, 4'd3, 4'd6, 4'd5, 4'd7
    };

endpackage

/* design/hrt_byte_if.sv */
// ----------------------------------------------------------------------------
// Request byte channel
// Valid/ready channel carrying one raw byte of the request stream.
// ----------------------------------------------------------------------------
interface hrt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

/* design/hrt_result_if.sv */
// ----------------------------------------------------------------------------
// Token result channel
// Valid/ready channel carrying the echoed byte and its classification.
// ----------------------------------------------------------------------------
interface hrt_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic [2:0] byte_kind;
    logic       line_end;
    logic [1:0] line_kind;
    logic [3:0] method_code;
    logic       request_done;
    logic [1:0] line_error;

    modport source (output valid, output byte_out, output byte_kind, output line_end,
                    output line_kind, output method_code, output request_done,
                    output line_error, input ready);
    modport sink   (input valid, input byte_out, input byte_kind, input line_end,
                    input line_kind, input method_code, input request_done,
                    input line_error, output ready);
endinterface

/* design/hrt_cfg_if.sv */
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel writing the line length limit register.
// ----------------------------------------------------------------------------
interface hrt_cfg_if;
    logic        valid;
    logic        ready;
    logic [11:0] len_limit;

    modport source (output valid, output len_limit, input ready);
    modport sink   (input valid, input len_limit, output ready);
endinterface

/* design/hrt_method_match.sv */
// ----------------------------------------------------------------------------
// Method matcher
// Narrows the set of candidate method names by one byte and resolves the
// method code from the surviving candidates.
// ----------------------------------------------------------------------------
module hrt_method_match
    import hrt_pkg::*;
(
    input  logic [7:0] i_cands,
    input  logic [3:0] i_pos,
    input  logic [7:0] i_byte,
    output t_match     o_match
);

    always_comb begin
        o_match.cands = '0;
        o_match.code  = METHOD_UNKNOWN;
        for (int i = 0; i < NUM_METHODS; i++) begin
            o_match.cands[i] = i_cands[i] && (i_pos < METHOD_LENS[i]) &&
                               (METHOD_CHARS[i][i_pos[2:0]] == i_byte);
        end
        // lowest index wins
        for (int i = NUM_METHODS - 1; i >= 0; i--) begin
            if (i_cands[i] && (METHOD_LENS[i] == i_pos)) begin
                o_match.code = 4'(i + 1);
            end
        end
        o_match.pos = (i_pos == POS_MAX) ? POS_MAX : i_pos + 4'd1;
    end

endmodule

/* design/hrt_core.sv */
// ----------------------------------------------------------------------------
// Tokenizer core
// Parser state registers and the per-byte classification logic.
// ----------------------------------------------------------------------------
module hrt_core
    import hrt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    input  logic [11:0] i_limit,
    output t_result     o_res
);

    logic        r_hdr, n_hdr;
    t_phase      r_phase, n_phase;
    logic [11:0] r_count, n_count;
    logic [7:0]  r_cands, n_cands;
    logic [3:0]  r_pos, n_pos;
    logic        r_url, n_url;
    logic [3:0]  r_held, n_held;
    t_err        r_perr, n_perr;

    t_match      match;

    hrt_method_match u_match (
        .i_cands (r_cands),
        .i_pos   (r_pos),
        .i_byte  (i_byte),
        .o_match (match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr   <= 1'b0;
            r_phase <= PH_METHOD;
            r_count <= '0;
            r_cands <= '1;
            r_pos   <= '0;
            r_url   <= 1'b0;
            r_held  <= METHOD_UNKNOWN;
            r_perr  <= ERR_NONE;
        end else if (i_step) begin
            r_hdr   <= n_hdr;
            r_phase <= n_phase;
            r_count <= n_count;
            r_cands <= n_cands;
            r_pos   <= n_pos;
            r_url   <= n_url;
            r_held  <= n_held;
            r_perr  <= n_perr;
        end
    end

    always_comb begin
        n_hdr   = r_hdr;
        n_phase = r_phase;
        n_count = r_count;
        n_cands = r_cands;
        n_pos   = r_pos;
        n_url   = r_url;
        n_held  = r_held;
        n_perr  = r_perr;

        o_res.byte_out     = i_byte;
        o_res.byte_kind    = KIND_NONE;
        o_res.line_end     = 1'b0;
        o_res.line_kind    = LK_REQUEST;
        o_res.method_code  = METHOD_UNKNOWN;
        o_res.request_done = 1'b0;
        o_res.line_error   = ERR_NONE;

        if (i_byte == CH_LF) begin
            o_res.line_end = 1'b1;
            if (!r_hdr) begin
                o_res.line_error = (r_perr == ERR_NONE && r_phase != PH_REST) ? ERR_REQ
                                                                              : r_perr;
                n_hdr = 1'b1;
            end else if (r_count == '0 && r_perr == ERR_NONE) begin
                o_res.line_kind    = LK_EMPTY;
                o_res.request_done = 1'b1;
            end else begin
                o_res.line_kind  = LK_HEADER;
                o_res.line_error = (r_perr == ERR_NONE &&
                                    (r_phase == PH_NAME || r_phase == PH_SKIP)) ? ERR_HDR
                                                                                : r_perr;
            end
        end else if (i_byte != CH_CR) begin
            if (r_count >= i_limit) begin
                n_perr = ERR_LONG;
            end else begin
                n_count = r_count + 12'd1;
                case (r_phase)
                    PH_METHOD: begin
                        if (i_byte == CH_SPACE) begin
                            if (r_pos == '0) begin
                                if (r_perr == ERR_NONE) n_perr = ERR_REQ;
                                n_phase = PH_DISCARD;
                            end else begin
                                n_held  = match.code;
                                n_phase = PH_URL;
                            end
                        end else begin
                            n_cands         = match.cands;
                            n_pos           = match.pos;
                            o_res.byte_kind = KIND_METHOD;
                        end
                    end
                    PH_URL: begin
                        if (i_byte == CH_SPACE) begin
                            if (!r_url) begin
                                if (r_perr == ERR_NONE) n_perr = ERR_REQ;
                                n_phase = PH_DISCARD;
                            end else begin
                                n_phase = PH_REST;
                            end
                        end else begin
                            n_url           = 1'b1;
                            o_res.byte_kind = KIND_URL;
                        end
                    end
                    PH_REST:  o_res.byte_kind = KIND_REST;
                    PH_NAME: begin
                        if (i_byte == CH_COLON) begin
                            if (r_count == '0) begin
                                if (r_perr == ERR_NONE) n_perr = ERR_HDR;
                                n_phase = PH_DISCARD;
                            end else begin
                                n_phase = PH_SKIP;
                            end
                        end else begin
                            o_res.byte_kind = KIND_NAME;
                        end
                    end
                    PH_SKIP:  n_phase = PH_VALUE;
                    PH_VALUE: o_res.byte_kind = KIND_VALUE;
                    default:  o_res.byte_kind = KIND_NONE;
                endcase
            end
        end

        // the code reflects a method resolved by this very byte
        o_res.method_code = n_held;

        if (o_res.line_end) begin
            if (o_res.request_done) begin
                n_hdr  = 1'b0;
                n_held = METHOD_UNKNOWN;
            end
            n_phase = o_res.request_done ? PH_METHOD : PH_NAME;
            n_count = '0;
            n_cands = '1;
            n_pos   = '0;
            n_url   = 1'b0;
            n_perr  = ERR_NONE;
        end
    end

    a_done_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.request_done) |=> (!r_hdr && r_held == METHOD_UNKNOWN &&
                                           r_phase == PH_METHOD))
        else $error("request end did not restart the parser");

    a_line_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.line_end) |=> (r_count == '0 && r_perr == ERR_NONE &&
                                       r_cands == 8'hFF))
        else $error("line state not cleared after LF");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_count >= i_limit && i_byte != CH_LF) |=> $stable(r_count))
        else $error("line count grew past the limit");

    a_header_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.line_end && !r_hdr) |=> (r_hdr && r_phase == PH_NAME))
        else $error("request line did not enter the header section");

endmodule

/* design/http_request_header_tokenizer_top.sv */
// A byte accepted from the input channel passes through the input register, then the
//   result register, before its result reaches the output channel.
// Throughput: one byte per cycle while the output channel is not stalled by ready low.
// Reset (synchronous, active low): parser expects a request line, method unknown,
//   line length limit 3000, both pipeline registers empty.
// ----------------------------------------------------------------------------
// HTTP request header tokenizer
// Splits a request byte stream into request line and header tokens.
// ----------------------------------------------------------------------------
module http_request_header_tokenizer_top
    import hrt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    hrt_cfg_if.sink      i_cfg,
    hrt_byte_if.sink     i_data,
    hrt_result_if.source o_result
);

    logic        r_max_len;
    logic [11:0] r_max_len_val;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    t_result     r_out;
    t_result     res;
    logic        advance;
    logic [11:0] limit;

    assign i_cfg.ready = 1'b1;

    // r_max_len marks that the register holds a written value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len     <= 1'b0;
            r_max_len_val <= MAX_LEN_RESET;
        end else if (i_cfg.valid) begin
            r_max_len     <= 1'b1;
            r_max_len_val <= i_cfg.len_limit;
        end
    end

    assign limit = (r_max_len_val < LINE_LIMIT_MAX) ? r_max_len_val : LINE_LIMIT_MAX;

    assign advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_data.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_data.ready) begin
            r_in_valid <= i_data.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_data.ready && i_data.valid) begin
            r_in_byte <= i_data.data_byte;
        end
    end

    hrt_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .i_limit (limit),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.byte_out     = r_out.byte_out;
    assign o_result.byte_kind    = r_out.byte_kind;
    assign o_result.line_end     = r_out.line_end;
    assign o_result.line_kind    = r_out.line_kind;
    assign o_result.method_code  = r_out.method_code;
    assign o_result.request_done = r_out.request_done;
    assign o_result.line_error   = r_out.line_error;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("pending result overwritten");

    a_cfg_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg.valid |=> (r_max_len && r_max_len_val == $past(i_cfg.len_limit)))
        else $error("configuration write lost");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("input register dropped a byte");

endmodule

/* test/http_request_header_tokenizer_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request header tokenizer testbench
// Streams directed and randomized request bytes into the tokenizer, models
// the line and token parsing per byte, and checks every result transfer in
// order against the modeled classification.
// ----------------------------------------------------------------------------
module http_request_header_tokenizer_top_test;
    import hrt_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hrt_cfg_if    cfg_ch ();
    hrt_byte_if   byte_ch ();
    hrt_result_if res_ch ();

    http_request_header_tokenizer_top i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_ch),
        .i_data   (byte_ch),
        .o_result (res_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // method names in code order, code = index + 1
    string method_names [8] = '{"HEAD", "OPTIONS", "GET", "POST",
                                "PUT", "DELETE", "TRACE", "CONNECT"};

    // parser model state
    logic [11:0] line_limit;
    logic        hdr_section;
    t_phase      parse_phase;
    logic [11:0] kept_count;
    logic [7:0]  method_cands;
    logic [3:0]  method_pos;
    logic        url_present;
    logic [3:0]  held_method;
    t_err        line_err;

    t_result     expected_tokens [$];
    int unsigned byte_count;
    int unsigned results_seen;
    int unsigned mismatch_count;
    int unsigned send_idle_pct;
    int unsigned take_idle_pct;
    t_result     got_token;
    t_result     want_token;

    function automatic void begin_line();
        if (hdr_section) begin
            parse_phase = PH_NAME;
        end else begin
            parse_phase = PH_METHOD;
        end
        kept_count   = '0;
        method_cands = '1;
        method_pos   = '0;
        url_present  = 1'b0;
        line_err     = ERR_NONE;
    endfunction

    // advance the parser model by one byte and return its classification
    function automatic t_result tokenize_byte(input logic [7:0] c);
        t_result r;
        logic    was_empty;
        int      i;
        r           = '0;
        r.byte_out  = c;
        r.byte_kind = KIND_NONE;
        r.line_kind = LK_REQUEST;
        r.line_error = ERR_NONE;
        if (c == CH_LF) begin
            r.line_end = 1'b1;
            if (!hdr_section) begin
                if (line_err == ERR_NONE && parse_phase != PH_REST) line_err = ERR_REQ;
                r.line_error = line_err;
                hdr_section  = 1'b1;
            end else if (kept_count == 0 && line_err == ERR_NONE) begin
                r.line_kind    = LK_EMPTY;
                r.request_done = 1'b1;
            end else begin
                r.line_kind = LK_HEADER;
                if (line_err == ERR_NONE && (parse_phase == PH_NAME || parse_phase == PH_SKIP))
                    line_err = ERR_HDR;
                r.line_error = line_err;
            end
        end else if (c != CH_CR) begin
            if (kept_count >= line_limit) begin
                line_err = ERR_LONG;
            end else begin
                was_empty  = (kept_count == 0);
                kept_count = kept_count + 12'd1;
                case (parse_phase)
                    PH_METHOD: begin
                        if (c == CH_SPACE) begin
                            if (method_pos == 0) begin
                                if (line_err == ERR_NONE) line_err = ERR_REQ;
                                parse_phase = PH_DISCARD;
                            end else begin
                                // lowest index wins when two names survive
                                held_method = METHOD_UNKNOWN;
                                for (i = 7; i >= 0; i--) begin
                                    if (method_cands[i] && method_names[i].len() == method_pos)
                                        held_method = 4'(i + 1);
                                end
                                parse_phase = PH_URL;
                            end
                        end else begin
                            for (i = 0; i < 8; i++) begin
                                if (!(method_pos < method_names[i].len() &&
                                      method_names[i][method_pos] == c))
                                    method_cands[i] = 1'b0;
                            end
                            if (method_pos != POS_MAX) method_pos = method_pos + 4'd1;
                            r.byte_kind = KIND_METHOD;
                        end
                    end
                    PH_URL: begin
                        if (c == CH_SPACE) begin
                            if (!url_present) begin
                                if (line_err == ERR_NONE) line_err = ERR_REQ;
                                parse_phase = PH_DISCARD;
                            end else begin
                                parse_phase = PH_REST;
                            end
                        end else begin
                            url_present = 1'b1;
                            r.byte_kind = KIND_URL;
                        end
                    end
                    PH_REST: r.byte_kind = KIND_REST;
                    PH_NAME: begin
                        if (c == CH_COLON) begin
                            if (was_empty) begin
                                if (line_err == ERR_NONE) line_err = ERR_HDR;
                                parse_phase = PH_DISCARD;
                            end else begin
                                parse_phase = PH_SKIP;
                            end
                        end else begin
                            r.byte_kind = KIND_NAME;
                        end
                    end
                    PH_SKIP: parse_phase = PH_VALUE;
                    PH_VALUE: r.byte_kind = KIND_VALUE;
                    default: ;
                endcase
            end
        end
        r.method_code = held_method;
        if (r.line_end) begin
            if (r.request_done) begin
                hdr_section = 1'b0;
                held_method = METHOD_UNKNOWN;
            end
            begin_line();
        end
        return r;
    endfunction

    function automatic string token_str(input t_result r);
        return $sformatf("byte %h kind %0d end %0b line %0d method %0d done %0b err %0d",
                         r.byte_out, r.byte_kind, r.line_end, r.line_kind,
                         r.method_code, r.request_done, r.line_error);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%s", msg);
    endtask

    // result side: random backpressure, in-order compare
    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= take_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got_token.byte_out     = res_ch.byte_out;
            got_token.byte_kind    = t_kind'(res_ch.byte_kind);
            got_token.line_end     = res_ch.line_end;
            got_token.line_kind    = t_line_kind'(res_ch.line_kind);
            got_token.method_code  = res_ch.method_code;
            got_token.request_done = res_ch.request_done;
            got_token.line_error   = t_err'(res_ch.line_error);
            if (expected_tokens.size() == 0) begin
                report_mismatch($sformatf("result %0d unexpected: %s",
                                          results_seen, token_str(got_token)));
            end else begin
                want_token = expected_tokens.pop_front();
                if (got_token !== want_token)
                    report_mismatch($sformatf("result %0d mismatch\n  exp %s\n  got %s",
                                              results_seen, token_str(want_token),
                                              token_str(got_token)));
            end
            results_seen++;
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        expected_tokens.push_back(tokenize_byte(b));
        byte_count++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        foreach (s[i]) send_byte(s[i]);
    endtask

    function automatic logic [7:0] rand_byte(input logic [7:0] lo, input logic [7:0] hi,
                                             input logic [7:0] avoid);
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(hi, lo));
        end while (b == avoid || b == CH_LF || b == CH_CR);
        return b;
    endfunction

    // random bytes from a range, with a stray CR now and then
    task automatic send_field(input int unsigned len, input logic [7:0] lo,
                              input logic [7:0] hi, input logic [7:0] avoid);
        repeat (len) begin
            if ($urandom_range(24) == 0) send_byte(CH_CR);
            send_byte(rand_byte(lo, hi, avoid));
        end
    endtask

    task automatic end_line();
        if ($urandom_range(3) == 0) send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic wait_idle();
        byte_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (expected_tokens.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_line_limit(input logic [11:0] v);
        wait_idle();
        cfg_ch.valid     <= 1'b1;
        cfg_ch.len_limit <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        line_limit = v;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_random_header();
        case ($urandom_range(11))
            0: send_field($urandom_range(10, 1), 8'h21, 8'h7E, CH_COLON);     // no colon
            1: begin                                                         // empty name
                send_byte(CH_COLON);
                send_field($urandom_range(8), 8'h00, 8'hFF, CH_LF);
            end
            2: begin                                                         // nothing after colon
                send_field($urandom_range(10, 1), 8'h21, 8'h7E, CH_COLON);
                send_byte(CH_COLON);
            end
            3: send_field($urandom_range(24), 8'h00, 8'hFF, CH_LF);
            default: begin
                send_field($urandom_range(10, 1), 8'h21, 8'h7E, CH_COLON);
                send_byte(CH_COLON);
                if ($urandom_range(3) != 0) send_byte(CH_SPACE);
                else send_byte(rand_byte(8'h00, 8'hFF, CH_LF));
                send_field($urandom_range(16), 8'h00, 8'hFF, CH_LF);
            end
        endcase
        end_line();
    endtask

    task automatic send_random_request();
        string       m;
        int unsigned pick;
        pick = $urandom_range(99);
        m    = method_names[$urandom_range(7)];
        if (pick < 8) begin
            case ($urandom_range(3))
                0: ;                                                         // empty first line
                1: begin                                                     // empty method
                    send_byte(CH_SPACE);
                    send_field($urandom_range(6, 1), 8'h21, 8'h7E, CH_LF);
                end
                2: begin                                                     // empty URL
                    send_text(m);
                    send_byte(CH_SPACE);
                    send_byte(CH_SPACE);
                    send_text("HTTP/1.0");
                end
                default: begin                                               // no second space
                    send_text(m);
                    send_byte(CH_SPACE);
                    send_field($urandom_range(8, 1), 8'h21, 8'hFF, CH_LF);
                end
            endcase
        end else if (pick < 14) begin
            send_field($urandom_range(24), 8'h00, 8'hFF, CH_LF);
        end else begin
            case ($urandom_range(10))
                7: send_text(m.substr(0, m.len() - 2));
                8: begin
                    send_text(m);
                    send_byte(rand_byte(8'h41, 8'h5A, CH_LF));
                end
                9: send_text(m.tolower());
                10: send_field($urandom_range(18, 1), 8'h21, 8'h7E, CH_LF);
                default: send_text(m);
            endcase
            send_byte(CH_SPACE);
            send_field($urandom_range(12, 1), 8'h21, 8'hFF, CH_LF);
            send_byte(CH_SPACE);
            if ($urandom_range(1) == 0) send_text("HTTP/1.1");
            else send_field($urandom_range(10), 8'h20, 8'h7E, CH_LF);
        end
        end_line();
        repeat ($urandom_range(4)) send_random_header();
        end_line();
    endtask

    task automatic test_directed_cases();
        send_byte(CH_LF);                           // empty request line
        send_byte(CH_LF);                           // ends the request
        send_text(" x");                            // empty method, rest discarded
        send_byte(CH_LF);
        send_text(":v");                            // empty header name
        send_byte(CH_LF);
        send_text("a");                             // header without colon
        send_byte(CH_LF);
        send_text("a:");                            // no byte after colon
        send_byte(CH_LF);
        send_byte(CH_CR);                           // CR-only line still ends the request
        send_byte(CH_LF);
        send_text("GET  ");                         // empty URL
        send_byte(CH_LF);
        send_byte(CH_LF);
        send_text("PUT /");                         // no second space, byte extremes in URL
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_LF);
        send_byte(CH_LF);
    endtask

    task automatic test_line_limit();
        write_line_limit(12'd0);                    // every byte dropped
        send_text("GET / H");
        send_byte(CH_LF);
        send_byte(CH_LF);
        write_line_limit(12'd1);
        send_text("GET / H");
        send_byte(CH_LF);
        send_text("a");
        send_byte(CH_LF);
        send_byte(CH_LF);
        write_line_limit(12'd5);                    // too long overrides parse state
        send_text("POST /ab HTTP");
        send_byte(CH_LF);
        send_text("Host: example");
        send_byte(CH_LF);
        send_byte(CH_LF);
        write_line_limit(12'd64);                   // a header line running past the limit
        send_text("GET / H");
        send_byte(CH_LF);
        repeat (66) send_byte(8'h61);
        send_byte(CH_LF);
        send_byte(CH_LF);
    endtask

    task automatic test_random_requests(input int unsigned quota);
        int unsigned stop_at;
        int unsigned n;
        stop_at = byte_count + quota;
        n       = 0;
        while (byte_count < stop_at) begin
            if (n % 6 == 0) begin
                case ($urandom_range(5))
                    0: write_line_limit(12'd1);
                    1: write_line_limit(12'd4095);
                    2: write_line_limit(MAX_LEN_RESET);
                    default: write_line_limit(12'($urandom_range(40, 3)));
                endcase
            end
            send_random_request();
            n++;
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.len_limit  = '0;
        res_ch.ready      = 1'b0;
        byte_count        = 0;
        results_seen      = 0;
        mismatch_count    = 0;
        line_limit        = MAX_LEN_RESET;
        hdr_section       = 1'b0;
        held_method       = METHOD_UNKNOWN;
        begin_line();
        send_idle_pct     = 23;
        take_idle_pct     = 80;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_cases();
        test_random_requests(530);

        send_idle_pct = 80;
        take_idle_pct = 23;
        test_line_limit();
        test_random_requests(530);

        send_idle_pct = 0;
        take_idle_pct = 0;
        test_random_requests(530);

        wait_idle();
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule
